// File: hdl/qnm_pkg.sv
// Shared types, constants and the step schedule for the quadrature NCO mixer.
package qnm_pkg;

    // Sample and oscillator formats
    localparam int SAMPLE_BITS   = 16;
    localparam int OSC_FRAC_BITS = 20;
    localparam int OSC_W         = OSC_FRAC_BITS + 2;   // Q2.F
    localparam int ROT_W         = SAMPLE_BITS + 1;     // rotated sample, negation safe
    localparam int MIX_W         = SAMPLE_BITS + 4;     // mix before the 1.1 gain
    localparam int MAG_W         = OSC_W + 3;           // squared magnitude, unsaturated

    // 1.95 in Q2.F, rounded
    localparam longint AMP_TARGET = (195 * (longint'(1) << OSC_FRAC_BITS) + 50) / 100;

    // 1.1 as a Q16 multiplier
    localparam int MIX_GAIN   = 72090;
    localparam int MIX_GAIN_W = 18;
    localparam int MIX_SHIFT  = 16;

    // Shared multiplier operand and accumulator widths
    localparam int OP_A_W = (OSC_W > MIX_W) ? OSC_W : MIX_W;
    localparam int OP_B_W = (OSC_W > MIX_GAIN_W) ? OSC_W : MIX_GAIN_W;
    localparam int PROD_W = OP_A_W + OP_B_W;
    localparam int ACC_W  = PROD_W + 1;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = OSC_W;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QSHIFT_EN = 2'd2;

    // Sequencer
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] LAST_STEP = 4'd15;

    // Multiplier A operand selects
    localparam logic [2:0] A_VQ   = 3'd0;
    localparam logic [2:0] A_VI   = 3'd1;
    localparam logic [2:0] A_RI   = 3'd2;
    localparam logic [2:0] A_RQ   = 3'd3;
    localparam logic [2:0] A_GAIN = 3'd4;
    localparam logic [2:0] A_MI   = 3'd5;
    localparam logic [2:0] A_MQ   = 3'd6;

    // Multiplier B operand selects
    localparam logic [2:0] B_COS  = 3'd0;
    localparam logic [2:0] B_SIN  = 3'd1;
    localparam logic [2:0] B_VQ   = 3'd2;
    localparam logic [2:0] B_VI   = 3'd3;
    localparam logic [2:0] B_OQ   = 3'd4;
    localparam logic [2:0] B_OI   = 3'd5;
    localparam logic [2:0] B_MIXK = 3'd6;

    // Finalize operations (round, saturate, write back)
    localparam logic [3:0] FIN_NONE = 4'd0;
    localparam logic [3:0] FIN_OQ   = 4'd1;
    localparam logic [3:0] FIN_OI   = 4'd2;
    localparam logic [3:0] FIN_MAG  = 4'd3;
    localparam logic [3:0] FIN_GAIN = 4'd4;
    localparam logic [3:0] FIN_MI   = 4'd5;
    localparam logic [3:0] FIN_MQ   = 4'd6;
    localparam logic [3:0] FIN_VQ   = 4'd7;
    localparam logic [3:0] FIN_VI   = 4'd8;
    localparam logic [3:0] FIN_OUTI = 4'd9;
    localparam logic [3:0] FIN_OUTQ = 4'd10;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] in_i;
        logic signed [SAMPLE_BITS-1:0] in_q;
        logic                          block_start;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_i;
        logic signed [SAMPLE_BITS-1:0] out_q;
        logic                          saturated;
    } t_out_item;

    // Per-cycle control from the sequencer.
    // a_sel/b_sel/first/neg belong to the product issued this cycle;
    // fin acts on the accumulator as it stands this cycle.
    typedef struct packed {
        logic [2:0] a_sel;
        logic [2:0] b_sel;
        logic       first;
        logic       neg;
        logic [3:0] fin;
    } t_ctl;

    // A product issued at a step passes the product register, then the accumulator register, before fin sees it.
    function automatic t_ctl step_ctl(input logic [STEP_W-1:0] step);
        t_ctl c;
        c = '{a_sel: A_VQ, b_sel: B_COS, first: 1'b1, neg: 1'b0, fin: FIN_NONE};
        case (step)
            4'd0:  begin c.a_sel = A_VQ;   c.b_sel = B_COS;  end
            4'd1:  begin c.a_sel = A_VI;   c.b_sel = B_SIN;  c.first = 1'b0; c.neg = 1'b1; end
            4'd2:  begin c.a_sel = A_VI;   c.b_sel = B_COS;  end
            4'd3:  begin c.a_sel = A_VQ;   c.b_sel = B_SIN;  c.first = 1'b0; c.fin = FIN_OQ; end
            4'd4:  begin c.a_sel = A_VQ;   c.b_sel = B_VQ;   end
            4'd5:  begin c.a_sel = A_VI;   c.b_sel = B_VI;   c.first = 1'b0; c.fin = FIN_OI; end
            4'd6:  begin c.a_sel = A_RI;   c.b_sel = B_OQ;   end
            4'd7:  begin c.a_sel = A_RQ;   c.b_sel = B_OI;   c.first = 1'b0; c.fin = FIN_MAG; end
            4'd8:  begin c.a_sel = A_RQ;   c.b_sel = B_OQ;   c.fin = FIN_GAIN; end
            4'd9:  begin c.a_sel = A_RI;   c.b_sel = B_OI;   c.first = 1'b0; c.neg = 1'b1;
                         c.fin = FIN_MI; end
            4'd10: begin c.a_sel = A_GAIN; c.b_sel = B_OQ;   end
            4'd11: begin c.a_sel = A_GAIN; c.b_sel = B_OI;   c.fin = FIN_MQ; end
            4'd12: begin c.a_sel = A_MI;   c.b_sel = B_MIXK; c.fin = FIN_VQ; end
            4'd13: begin c.a_sel = A_MQ;   c.b_sel = B_MIXK; c.fin = FIN_VI; end
            4'd14: begin c.fin = FIN_OUTI; end
            4'd15: begin c.fin = FIN_OUTQ; end
            default: begin c.fin = FIN_NONE; end
        endcase
        return c;
    endfunction

endpackage

// File: hdl/qnm_seq.sv
// Step sequencer: idle / run / hand-off states and the step counter.
module qnm_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_out_free,
    output logic             o_in_ready,
    output logic             o_load,
    output qnm_pkg::t_ctl    o_ctl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic [qnm_pkg::STEP_W-1:0]  r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (i_start) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_step = r_step + 1'b1;
                if (r_step == qnm_pkg::LAST_STEP) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        o_ctl = qnm_pkg::step_ctl(r_step);
        if (r_state != ST_RUN) begin
            o_ctl.fin = qnm_pkg::FIN_NONE;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_load     = (r_state == ST_DONE) && i_out_free;

endmodule

// File: hdl/qnm_mac.sv
// Shared signed multiplier with a registered product and an accumulator behind it.
module qnm_mac (
    input  logic                                 i_clk,
    input  logic signed [qnm_pkg::OP_A_W-1:0]    i_a,
    input  logic signed [qnm_pkg::OP_B_W-1:0]    i_b,
    input  logic                                 i_first,
    input  logic                                 i_neg,
    output logic signed [qnm_pkg::ACC_W-1:0]     o_acc
);

    logic signed [qnm_pkg::PROD_W-1:0] r_prod;
    logic                              r_first;
    logic                              r_neg;
    logic signed [qnm_pkg::ACC_W-1:0]  r_acc;
    logic signed [qnm_pkg::ACC_W-1:0]  prod_x;
    logic signed [qnm_pkg::ACC_W-1:0]  base;

    assign prod_x = qnm_pkg::ACC_W'(r_prod);
    assign base   = r_first ? '0 : r_acc;

    always_ff @(posedge i_clk) begin
        r_prod  <= qnm_pkg::PROD_W'(i_a * i_b);
        r_first <= i_first;
        r_neg   <= i_neg;
        r_acc   <= r_neg ? (base - prod_x) : (base + prod_x);
    end

    assign o_acc = r_acc;

endmodule

// File: hdl/quadrature_nco_mixer_unit.sv
// Top level of the quadrature NCO mixer: Fs/4 rotation, recursive oscillator, mix.
//
//  channel | signals                                  | transfer
//  --------+------------------------------------------+-------------------------------
//  input   | i_in_valid, o_in_ready, i_in_data        | transaction when valid & ready
//  output  | o_out_valid, i_out_ready, o_out_data     | transaction when valid & ready
//  config  | i_cfg_we, i_cfg_idx, i_cfg_data          | write when i_cfg_we, no wait
//
// One input transaction occupies the block from its accepting edge to the next possible
// one: 16 run steps (14 products through the single multiplier, one product per step,
// plus two steps of pipeline drain), a hand-off state that loads the output register,
// then the idle state with o_in_ready high. The output register takes the result on
// the edge that leaves hand-off.
// A full output register that is not taken holds the sequencer in hand-off.
// Synchronous active-low reset loads the config defaults, quarter phase 0 and
// the oscillator vector (1.0, 0); no clearing pass is needed.
module quadrature_nco_mixer_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  qnm_pkg::t_in_item                    i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output qnm_pkg::t_out_item                   o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [qnm_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [qnm_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int S     = qnm_pkg::SAMPLE_BITS;
    localparam int F     = qnm_pkg::OSC_FRAC_BITS;
    localparam int OW    = qnm_pkg::OSC_W;
    localparam int XW    = qnm_pkg::ACC_W + 1;   // accumulator plus rounding headroom
    localparam int GW    = qnm_pkg::MAG_W + 1;

    // Quarter-phase rotation codes
    localparam logic [1:0] QP_0   = 2'd0;
    localparam logic [1:0] QP_90  = 2'd1;
    localparam logic [1:0] QP_180 = 2'd2;
    localparam logic [1:0] QP_270 = 2'd3;

    localparam logic signed [OW-1:0] OSC_ONE = OW'(longint'(1) << F);
    localparam logic signed [OW-1:0] OSC_MAX = OW'((longint'(1) << (OW - 1)) - 1);
    localparam logic signed [OW-1:0] OSC_MIN = OW'(-(longint'(1) << (OW - 1)));
    localparam logic signed [S-1:0]  SMP_MAX = S'((longint'(1) << (S - 1)) - 1);
    localparam logic signed [S-1:0]  SMP_MIN = S'(-(longint'(1) << (S - 1)));

    localparam logic signed [XW-1:0] OSC_MAX_X = XW'((longint'(1) << (OW - 1)) - 1);
    localparam logic signed [XW-1:0] OSC_MIN_X = XW'(-(longint'(1) << (OW - 1)));
    localparam logic signed [XW-1:0] SMP_MAX_X = XW'((longint'(1) << (S - 1)) - 1);
    localparam logic signed [XW-1:0] SMP_MIN_X = XW'(-(longint'(1) << (S - 1)));
    localparam logic signed [XW-1:0] HALF_OSC  = XW'(longint'(1) << (F - 1));
    localparam logic signed [XW-1:0] HALF_MIX  = XW'(longint'(1) << (qnm_pkg::MIX_SHIFT - 1));

    localparam logic signed [GW-1:0] AMP_X     = GW'(qnm_pkg::AMP_TARGET);
    localparam logic signed [GW-1:0] OSC_MAX_G = GW'((longint'(1) << (OW - 1)) - 1);
    localparam logic signed [GW-1:0] OSC_MIN_G = GW'(-(longint'(1) << (OW - 1)));

    localparam logic signed [qnm_pkg::OP_B_W-1:0] MIX_K = qnm_pkg::OP_B_W'(qnm_pkg::MIX_GAIN);

    // Configuration
    logic signed [OW-1:0]  r_step_cos;
    logic signed [OW-1:0]  r_step_sin;
    logic                  r_qs_en;

    // Persistent state
    logic [1:0]            r_phase;
    logic signed [OW-1:0]  r_vi;
    logic signed [OW-1:0]  r_vq;

    // Working registers for one transaction
    logic signed [qnm_pkg::ROT_W-1:0] r_ri;
    logic signed [qnm_pkg::ROT_W-1:0] r_rq;
    logic signed [OW-1:0]             r_oq;
    logic signed [OW-1:0]             r_oi;
    logic signed [qnm_pkg::MAG_W-1:0] r_mag;
    logic signed [OW-1:0]             r_gain;
    logic signed [qnm_pkg::MIX_W-1:0] r_mi;
    logic signed [qnm_pkg::MIX_W-1:0] r_mq;
    logic signed [S-1:0]              r_res_i;
    logic signed [S-1:0]              r_res_q;
    logic                             r_clip;

    // Output register
    logic                  r_out_valid;
    qnm_pkg::t_out_item    r_out;

    // Sequencer hookup
    logic                  in_accept;
    logic                  out_free;
    logic                  seq_load;
    qnm_pkg::t_ctl         ctl;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;

    qnm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_accept),
        .i_out_free (out_free),
        .o_in_ready (o_in_ready),
        .o_load     (seq_load),
        .o_ctl      (ctl)
    );

    // ---------------------------------------------------------------
    // Fs/4 rotation at input transaction time (no multiplier needed).
    // block_start forces phase 0; counter advances even when disabled.
    // ---------------------------------------------------------------
    logic [1:0]                       cur_phase;
    logic [1:0]                       rot_sel;
    logic signed [qnm_pkg::ROT_W-1:0] xi;
    logic signed [qnm_pkg::ROT_W-1:0] xq;
    logic signed [qnm_pkg::ROT_W-1:0] rot_i;
    logic signed [qnm_pkg::ROT_W-1:0] rot_q;

    assign cur_phase = i_in_data.block_start ? QP_0 : r_phase;
    assign rot_sel   = r_qs_en ? cur_phase : QP_0;
    assign xi        = qnm_pkg::ROT_W'(i_in_data.in_i);
    assign xq        = qnm_pkg::ROT_W'(i_in_data.in_q);

    always_comb begin
        case (rot_sel)
            QP_0:    begin rot_i = xi;  rot_q = xq;  end
            QP_90:   begin rot_i = -xq; rot_q = xi;  end
            QP_180:  begin rot_i = -xi; rot_q = -xq; end
            QP_270:  begin rot_i = xq;  rot_q = -xi; end
            default: begin rot_i = xi;  rot_q = xq;  end
        endcase
    end

    // ---------------------------------------------------------------
    // Shared multiplier operand muxes
    // ---------------------------------------------------------------
    logic signed [qnm_pkg::OP_A_W-1:0] op_a;
    logic signed [qnm_pkg::OP_B_W-1:0] op_b;
    logic signed [qnm_pkg::ACC_W-1:0]  acc;

    always_comb begin
        case (ctl.a_sel)
            qnm_pkg::A_VQ:   op_a = qnm_pkg::OP_A_W'(r_vq);
            qnm_pkg::A_VI:   op_a = qnm_pkg::OP_A_W'(r_vi);
            qnm_pkg::A_RI:   op_a = qnm_pkg::OP_A_W'(r_ri);
            qnm_pkg::A_RQ:   op_a = qnm_pkg::OP_A_W'(r_rq);
            qnm_pkg::A_GAIN: op_a = qnm_pkg::OP_A_W'(r_gain);
            qnm_pkg::A_MI:   op_a = qnm_pkg::OP_A_W'(r_mi);
            qnm_pkg::A_MQ:   op_a = qnm_pkg::OP_A_W'(r_mq);
            default:         op_a = '0;
        endcase
        case (ctl.b_sel)
            qnm_pkg::B_COS:  op_b = qnm_pkg::OP_B_W'(r_step_cos);
            qnm_pkg::B_SIN:  op_b = qnm_pkg::OP_B_W'(r_step_sin);
            qnm_pkg::B_VQ:   op_b = qnm_pkg::OP_B_W'(r_vq);
            qnm_pkg::B_VI:   op_b = qnm_pkg::OP_B_W'(r_vi);
            qnm_pkg::B_OQ:   op_b = qnm_pkg::OP_B_W'(r_oq);
            qnm_pkg::B_OI:   op_b = qnm_pkg::OP_B_W'(r_oi);
            qnm_pkg::B_MIXK: op_b = MIX_K;
            default:         op_b = '0;
        endcase
    end

    qnm_mac u_mac (
        .i_clk   (i_clk),
        .i_a     (op_a),
        .i_b     (op_b),
        .i_first (ctl.first),
        .i_neg   (ctl.neg),
        .o_acc   (acc)
    );

    // ---------------------------------------------------------------
    // Finalize: round half up (add half, arithmetic shift); oscillator and output
    // values are then clipped. The output gain stage shifts by 16, the other rounded values by F.
    // ---------------------------------------------------------------
    logic                  mix_fin;
    logic signed [XW-1:0]  rsum;
    logic signed [XW-1:0]  rnd;
    logic signed [OW-1:0]  osc_sat;
    logic signed [S-1:0]   smp_sat;
    logic                  smp_clip;
    logic signed [GW-1:0]  gdiff;
    logic signed [OW-1:0]  gain_sat;

    assign mix_fin = (ctl.fin == qnm_pkg::FIN_OUTI) || (ctl.fin == qnm_pkg::FIN_OUTQ);
    assign rsum    = XW'(acc) + (mix_fin ? HALF_MIX : HALF_OSC);
    assign rnd     = mix_fin ? (rsum >>> qnm_pkg::MIX_SHIFT) : (rsum >>> F);

    always_comb begin
        if (rnd > OSC_MAX_X) begin
            osc_sat = OSC_MAX;
        end else if (rnd < OSC_MIN_X) begin
            osc_sat = OSC_MIN;
        end else begin
            osc_sat = OW'(rnd);
        end

        smp_clip = 1'b1;
        if (rnd > SMP_MAX_X) begin
            smp_sat = SMP_MAX;
        end else if (rnd < SMP_MIN_X) begin
            smp_sat = SMP_MIN;
        end else begin
            smp_sat  = S'(rnd);
            smp_clip = 1'b0;
        end
    end

    // Amplitude control: 1.95 - |v|^2, clipped to Q2.F
    assign gdiff = AMP_X - GW'(r_mag);

    always_comb begin
        if (gdiff > OSC_MAX_G) begin
            gain_sat = OSC_MAX;
        end else if (gdiff < OSC_MIN_G) begin
            gain_sat = OSC_MIN;
        end else begin
            gain_sat = OW'(gdiff);
        end
    end

    // ---------------------------------------------------------------
    // Control and state registers (reset)
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_cos  <= OSC_ONE;
            r_step_sin  <= '0;
            r_qs_en     <= 1'b1;
            r_phase     <= QP_0;
            r_vi        <= OSC_ONE;
            r_vq        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    qnm_pkg::REG_STEP_COS:  r_step_cos <= i_cfg_data;
                    qnm_pkg::REG_STEP_SIN:  r_step_sin <= i_cfg_data;
                    qnm_pkg::REG_QSHIFT_EN: r_qs_en    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_phase <= cur_phase + 2'd1;
            end
            if (ctl.fin == qnm_pkg::FIN_VQ) begin
                r_vq <= osc_sat;
            end
            if (ctl.fin == qnm_pkg::FIN_VI) begin
                r_vi <= osc_sat;
            end
            if (seq_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers (no reset)
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ri <= rot_i;
            r_rq <= rot_q;
        end
        case (ctl.fin)
            qnm_pkg::FIN_OQ:   r_oq    <= osc_sat;
            qnm_pkg::FIN_OI:   r_oi    <= osc_sat;
            qnm_pkg::FIN_MAG:  r_mag   <= qnm_pkg::MAG_W'(rnd);
            qnm_pkg::FIN_GAIN: r_gain  <= gain_sat;
            qnm_pkg::FIN_MI:   r_mi    <= qnm_pkg::MIX_W'(rnd);
            qnm_pkg::FIN_MQ:   r_mq    <= qnm_pkg::MIX_W'(rnd);
            qnm_pkg::FIN_OUTI: begin
                r_res_i <= smp_sat;
                r_clip  <= smp_clip;
            end
            qnm_pkg::FIN_OUTQ: begin
                r_res_q <= smp_sat;
                r_clip  <= r_clip | smp_clip;
            end
            default: ;
        endcase
        if (seq_load) begin
            r_out.out_i     <= r_res_i;
            r_out.out_q     <= r_res_q;
            r_out.saturated <= r_clip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    // The block is busy for the whole run after taking a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_in_ready)
        else $error("input ready right after an input transaction");

    // A result only appears after the block has been working on an item
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result valid without a preceding run");

    // A clipped result must sit on a rail in at least one component
    a_clip_on_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.saturated) |->
            (o_out_data.out_i == SMP_MAX || o_out_data.out_i == SMP_MIN ||
             o_out_data.out_q == SMP_MAX || o_out_data.out_q == SMP_MIN))
        else $error("saturated flag without a clipped component");

    // block_start puts this item at phase 0, so the next one sees phase 1
    a_block_start_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.block_start) |=> (r_phase == QP_90))
        else $error("quarter phase not realigned by block start");
`endif

endmodule

// File: tb/tb_quadrature_nco_mixer_unit.sv
// Self-checking testbench for the quadrature NCO mixer: directed table, then random phases.
module tb_quadrature_nco_mixer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Run shape
    // ------------------------------------------------------------------
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 297;   // plus the directed rows, about 1800 samples
    localparam int IDLE_GUARD      = 2;     // quiet cycles before a register write
    localparam int SETTLE_CYCLES   = 40;    // > one full sample plus margin
    localparam int WATCHDOG_LIMIT  = 1000;  // cycles without any transaction or write

    localparam int SMP_MAX = 32767;
    localparam int SMP_MIN = -32768;

    localparam longint OSC_ONE = longint'(1) << qnm_pkg::OSC_FRAC_BITS;

    // Register write values
    localparam logic [qnm_pkg::CFG_W-1:0] STEP_ONE     =
        qnm_pkg::CFG_W'(1 << qnm_pkg::OSC_FRAC_BITS);                          // 1.0
    localparam logic [qnm_pkg::CFG_W-1:0] STEP_QUARTER =
        qnm_pkg::CFG_W'(1 << (qnm_pkg::OSC_FRAC_BITS - 2));                    // 0.25
    localparam logic [qnm_pkg::CFG_W-1:0] STEP_ZERO    = '0;
    localparam logic [qnm_pkg::CFG_W-1:0] STEP_MAX     =
        {1'b0, {(qnm_pkg::CFG_W-1){1'b1}}};                                    // just under 2.0
    localparam logic [qnm_pkg::CFG_W-1:0] STEP_MIN     =
        {1'b1, {(qnm_pkg::CFG_W-1){1'b0}}};                                    // -2.0
    localparam logic [qnm_pkg::CFG_W-1:0] CFG_ON       = qnm_pkg::CFG_W'(1);
    localparam logic [qnm_pkg::CFG_W-1:0] CFG_OFF      = '0;
    localparam logic [qnm_pkg::CFG_W-1:0] CFG_ALL_ONES = '1;

    // Index past the end of the register list; writes there must be dropped
    localparam logic [qnm_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    // Quarter-phase rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // Directed table row: either a register write or one sample
    typedef enum bit {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind                      kind;
        logic [qnm_pkg::CFG_IDX_W-1:0]  idx;
        logic [qnm_pkg::CFG_W-1:0]      data;
        qnm_pkg::t_in_item              item;
        logic                           known;   // expected result typed in below
        qnm_pkg::t_out_item             want;
    } t_plan_row;

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    qnm_pkg::t_in_item             i_in_data   = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    qnm_pkg::t_out_item            o_out_data;
    logic                          i_cfg_we    = 1'b0;
    logic [qnm_pkg::CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [qnm_pkg::CFG_W-1:0]     i_cfg_data  = '0;

    // Typed-in expectation travels alongside the input payload
    logic                 r_known      = 1'b0;
    qnm_pkg::t_out_item   r_known_want = '0;

    // Set per phase; both sides only stall while it is high
    logic                 idle_on      = 1'b1;

    // Samples in flight, updated at the edge so the sender reads it race-free
    int                   r_outstanding = 0;

    int n_sent    = 0;
    int n_writes  = 0;
    int n_checked = 0;
    int n_clipped = 0;
    int n_fail    = 0;
    int stall_cnt = 0;

    // Mirror of the mixer: config registers and oscillator/rotation state
    longint     cos_step;
    longint     sin_step;
    logic       quarter_en;
    logic [1:0] quarter_cnt;
    longint     nco_i;
    longint     nco_q;

    qnm_pkg::t_out_item  pending_mix [$];

    quadrature_nco_mixer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Fixed-point helpers for the mixer mirror
    // ------------------------------------------------------------------

    // Clip to a signed w-bit range, flag when it bites
    function automatic longint clamp_bits(input longint v, input int w, inout bit clipped);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -(longint'(1) <<< (w - 1));
        if (v > hi) begin
            clipped = 1'b1;
            return hi;
        end
        if (v < lo) begin
            clipped = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Round to nearest, ties toward +inf: add half, arithmetic shift (floor).
    // Product sums here stay far below 64 bits, so summing first is exact.
    function automatic longint round_shift(input longint p, input int n);
        return (p + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    // One sample through rotation, oscillator step and mix; advances the mirror
    function automatic qnm_pkg::t_out_item mix_predict(input qnm_pkg::t_in_item x);
        longint              xi, xq, ri, rq;
        longint              oq, oi, mag, gain, mi, mq;
        bit                  osc_clip;
        bit                  out_clip;
        logic [1:0]          rot;
        qnm_pkg::t_out_item  r;
        osc_clip = 1'b0;
        out_clip = 1'b0;
        xi = longint'($signed(x.in_i));
        xq = longint'($signed(x.in_q));

        if (x.block_start)
            quarter_cnt = ROT_0;
        rot = quarter_cnt;
        quarter_cnt = quarter_cnt + 2'd1;

        // counter runs even with rotation off, so it stays block-aligned
        ri = xi;
        rq = xq;
        if (quarter_en) begin
            case (rot)
                ROT_90:  begin ri = -xq; rq =  xi; end
                ROT_180: begin ri = -xi; rq = -xq; end
                ROT_270: begin ri =  xq; rq = -xi; end
                default: begin end
            endcase
        end

        oq   = clamp_bits(round_shift(nco_q * cos_step - nco_i * sin_step,
                                      qnm_pkg::OSC_FRAC_BITS),
                          qnm_pkg::OSC_W, osc_clip);
        oi   = clamp_bits(round_shift(nco_i * cos_step + nco_q * sin_step,
                                      qnm_pkg::OSC_FRAC_BITS),
                          qnm_pkg::OSC_W, osc_clip);
        mag  = round_shift(nco_q * nco_q + nco_i * nco_i, qnm_pkg::OSC_FRAC_BITS);
        gain = clamp_bits(qnm_pkg::AMP_TARGET - mag, qnm_pkg::OSC_W, osc_clip);
        nco_q = clamp_bits(round_shift(gain * oq, qnm_pkg::OSC_FRAC_BITS),
                           qnm_pkg::OSC_W, osc_clip);
        nco_i = clamp_bits(round_shift(gain * oi, qnm_pkg::OSC_FRAC_BITS),
                           qnm_pkg::OSC_W, osc_clip);

        // mix uses the stepped vector, not the amplitude-corrected one
        mi = round_shift(ri * oq + rq * oi, qnm_pkg::OSC_FRAC_BITS);
        mq = round_shift(rq * oq - ri * oi, qnm_pkg::OSC_FRAC_BITS);
        mi = clamp_bits(round_shift(mi * qnm_pkg::MIX_GAIN, qnm_pkg::MIX_SHIFT),
                        qnm_pkg::SAMPLE_BITS, out_clip);
        mq = clamp_bits(round_shift(mq * qnm_pkg::MIX_GAIN, qnm_pkg::MIX_SHIFT),
                        qnm_pkg::SAMPLE_BITS, out_clip);

        r.out_i     = mi[qnm_pkg::SAMPLE_BITS-1:0];
        r.out_q     = mq[qnm_pkg::SAMPLE_BITS-1:0];
        r.saturated = out_clip;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------
    function automatic t_plan_row sample_row(input int si, input int sq, input bit bs);
        t_plan_row r;
        r = '0;
        r.kind             = ROW_SAMPLE;
        r.item.in_i        = si[qnm_pkg::SAMPLE_BITS-1:0];
        r.item.in_q        = sq[qnm_pkg::SAMPLE_BITS-1:0];
        r.item.block_start = bs;
        return r;
    endfunction

    function automatic t_plan_row known_row(input int si, input int sq, input bit bs,
                                            input int wi, input int wq, input bit wsat);
        t_plan_row r;
        r = sample_row(si, sq, bs);
        r.known          = 1'b1;
        r.want.out_i     = wi[qnm_pkg::SAMPLE_BITS-1:0];
        r.want.out_q     = wq[qnm_pkg::SAMPLE_BITS-1:0];
        r.want.saturated = wsat;
        return r;
    endfunction

    function automatic t_plan_row write_row(input logic [qnm_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [qnm_pkg::CFG_W-1:0] data);
        t_plan_row r;
        r = '0;
        r.kind = ROW_WRITE;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    // Random sample value, leaning on the range ends now and then
    function automatic logic [qnm_pkg::SAMPLE_BITS-1:0] pick_sample();
        logic [31:0] rv;
        rv = $urandom();
        case ($urandom_range(0, 9))
            0:       return SMP_MIN[qnm_pkg::SAMPLE_BITS-1:0];
            1:       return SMP_MAX[qnm_pkg::SAMPLE_BITS-1:0];
            2:       return '0;
            3:       return '1;
            default: return rv[qnm_pkg::SAMPLE_BITS-1:0];
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender side tasks
    // ------------------------------------------------------------------

    // Hold off input until every sample in flight has come back out
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (r_outstanding != 0)
            @(posedge i_clk);
    endtask

    // Registers only change with the block idle
    task automatic write_reg(input logic [qnm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [qnm_pkg::CFG_W-1:0] data);
        wait_all_results();
        repeat (IDLE_GUARD) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        n_writes++;
    endtask

    // One input transaction. With idling on, the gap is counted either from the
    // previous transaction (lands inside the busy window) or from the
    // pipe running empty (lands while the block sits ready).
    task automatic send_item(input qnm_pkg::t_in_item item, input logic known,
                             input qnm_pkg::t_out_item want);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (idle_on && $urandom_range(0, 1) == 1)
            wait_all_results();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_in_data    <= item;
        r_known      <= known;
        r_known_want <= want;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        n_sent++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall counted from when a result shows up,
    // ready held high throughout when idling is off
    // ------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = idle_on ? $urandom_range(0, 7) : 0;
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                do @(posedge i_clk); while (!o_out_valid);
                repeat (gap - 1) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: checks results, mirrors register writes, predicts on
    // every accepted input. All reads see pre-edge values.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        qnm_pkg::t_out_item want;
        qnm_pkg::t_out_item got;
        qnm_pkg::t_out_item model_out;
        bit                 in_acc;
        bit                 out_acc;
        in_acc  = i_in_valid && o_in_ready;
        out_acc = o_out_valid && i_out_ready;
        if (!i_rst_n) begin
            cos_step    = OSC_ONE;
            sin_step    = 0;
            quarter_en  = 1'b1;
            quarter_cnt = ROT_0;
            nco_i       = OSC_ONE;
            nco_q       = 0;
            r_outstanding <= 0;
        end else begin
            if (out_acc) begin
                got = o_out_data;
                if (pending_mix.size() == 0) begin
                    $error("result transaction with nothing pending: out_i %0d, out_q %0d",
                           $signed(got.out_i), $signed(got.out_q));
                    n_fail++;
                end else begin
                    want = pending_mix.pop_front();
                    n_checked++;
                    if (want.saturated)
                        n_clipped++;
                    if (got.out_i !== want.out_i) begin
                        $error("out_i: expected %0d, got %0d",
                               $signed(want.out_i), $signed(got.out_i));
                        n_fail++;
                    end
                    if (got.out_q !== want.out_q) begin
                        $error("out_q: expected %0d, got %0d",
                               $signed(want.out_q), $signed(got.out_q));
                        n_fail++;
                    end
                    if (got.saturated !== want.saturated) begin
                        $error("saturated: expected %0b, got %0b",
                               want.saturated, got.saturated);
                        n_fail++;
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    qnm_pkg::REG_STEP_COS:  cos_step   = longint'($signed(i_cfg_data));
                    qnm_pkg::REG_STEP_SIN:  sin_step   = longint'($signed(i_cfg_data));
                    qnm_pkg::REG_QSHIFT_EN: quarter_en = i_cfg_data[0];
                    default:                begin end   // unmapped index: dropped
                endcase
            end

            // mirror always advances; a typed-in row overrides what is expected
            if (in_acc) begin
                model_out = mix_predict(i_in_data);
                pending_mix.push_back(r_known ? r_known_want : model_out);
            end

            r_outstanding <= r_outstanding + (in_acc ? 1 : 0) - (out_acc ? 1 : 0);
        end
    end

    // Watchdog: too long with no transaction on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_plan_row          plan [$];
        qnm_pkg::t_in_item  x;
        real                ang;
        int                 c_val;
        int                 s_val;

        // Right after reset: step 1.0/0 keeps the oscillator on the real axis
        // near unit amplitude, so zero in gives zero out and full-scale inputs
        // clip on both outputs.
        plan.push_back(known_row(0, 0, 1'b1, 0, 0, 1'b0));
        plan.push_back(known_row(SMP_MIN, SMP_MAX, 1'b1, SMP_MAX, SMP_MAX, 1'b1));
        plan.push_back(known_row(SMP_MAX, SMP_MIN, 1'b1, SMP_MIN, SMP_MIN, 1'b1));
        // quarter phases 1..3, negating the most negative sample on each
        plan.push_back(sample_row(1234, SMP_MIN, 1'b0));
        plan.push_back(sample_row(SMP_MIN, SMP_MIN, 1'b0));
        plan.push_back(sample_row(SMP_MIN, 5, 1'b0));
        plan.push_back(sample_row(SMP_MAX, SMP_MAX, 1'b0));   // counter wraps to 0
        plan.push_back(sample_row(-1, 1, 1'b1));              // block restart mid-count
        plan.push_back(sample_row(1, -1, 1'b0));
        // rotation off: samples pass straight, counter still runs and restarts
        plan.push_back(write_row(qnm_pkg::REG_QSHIFT_EN, CFG_OFF));
        plan.push_back(sample_row(SMP_MIN, SMP_MAX, 1'b0));
        plan.push_back(sample_row(-20000, 12345, 1'b1));
        plan.push_back(sample_row(777, -32000, 1'b0));
        // write past the register list must change nothing
        plan.push_back(write_row(REG_UNMAPPED, CFG_ALL_ONES));
        plan.push_back(sample_row(300, -300, 1'b0));
        plan.push_back(write_row(qnm_pkg::REG_QSHIFT_EN, CFG_ON));
        plan.push_back(sample_row(20000, -20000, 1'b0));
        // extreme steps drive the oscillator into saturation (step, gain, vector)
        plan.push_back(write_row(qnm_pkg::REG_STEP_COS, STEP_MAX));
        plan.push_back(write_row(qnm_pkg::REG_STEP_SIN, STEP_MAX));
        plan.push_back(sample_row(8000, 8000, 1'b0));
        plan.push_back(sample_row(-8000, 16000, 1'b0));
        plan.push_back(write_row(qnm_pkg::REG_STEP_COS, STEP_MIN));
        plan.push_back(write_row(qnm_pkg::REG_STEP_SIN, STEP_MIN));
        plan.push_back(sample_row(SMP_MAX, SMP_MIN, 1'b0));
        // pull the vector back from the rails without hitting zero, then regrow
        plan.push_back(write_row(qnm_pkg::REG_STEP_COS, STEP_QUARTER));
        plan.push_back(write_row(qnm_pkg::REG_STEP_SIN, STEP_ZERO));
        plan.push_back(sample_row(1000, 2000, 1'b0));
        plan.push_back(write_row(qnm_pkg::REG_STEP_COS, STEP_ONE));
        plan.push_back(sample_row(4000, -4000, 1'b1));
        plan.push_back(sample_row(-123, 456, 1'b0));
        plan.push_back(sample_row(SMP_MAX, 0, 1'b0));

        // synchronous reset, released once
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_WRITE)
                write_reg(plan[k].idx, plan[k].data);
            else
                send_item(plan[k].item, plan[k].known, plan[k].want);
        end

        // Random phases: each gets a new unit-magnitude step (the first a slow
        // one), rotation alternating on/off, and every third runs with no idling.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 0)
                ang = $urandom_range(1, 2000) * 1.0e-4;
            else
                ang = $urandom_range(0, 62831) * 1.0e-4;
            c_val = $rtoi($cos(ang) * real'(OSC_ONE));
            s_val = $rtoi($sin(ang) * real'(OSC_ONE));
            write_reg(qnm_pkg::REG_STEP_COS, c_val[qnm_pkg::CFG_W-1:0]);
            write_reg(qnm_pkg::REG_STEP_SIN, s_val[qnm_pkg::CFG_W-1:0]);
            write_reg(qnm_pkg::REG_QSHIFT_EN, (ph % 2 == 0) ? CFG_ON : CFG_OFF);
            idle_on <= ((ph % 3) != 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                x.in_i        = pick_sample();
                x.in_q        = pick_sample();
                x.block_start = ($urandom_range(0, 7) == 0);
                send_item(x, 1'b0, '0);
            end
        end

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("summary: %0d samples mixed, %0d results checked, %0d of them clipped",
                 n_sent, n_checked, n_clipped);
        $display("summary: %0d register writes over unit, extreme and random phase steps",
                 n_writes);
        if (n_fail == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
hdl/qnm_pkg.sv
hdl/qnm_seq.sv
hdl/qnm_mac.sv
hdl/quadrature_nco_mixer_unit.sv
tb/tb_quadrature_nco_mixer_unit.sv
